[rtl/lpcp_pkg.sv]
`timescale 1ns / 1ps
// Shared constants, codes and types for the lidar point projection block.
// Used by the stream interfaces, the divider, the square root and the top level.
package lpcp_pkg;

	// field widths
	localparam int PT_W       = 20;
	localparam int INT_W      = 8;
	localparam int PIX_W      = 18;
	localparam int IDX_W      = 8;
	localparam int OUTC_W     = 3;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_ROT0  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ROT1  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ROT2  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_TRANS = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_INTR  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_SIZE  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_COLOR = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_VSRC  = 3'd7;

	// outcome codes
	localparam logic [OUTC_W-1:0] OUTC_KEPT    = 3'd0;
	localparam logic [OUTC_W-1:0] OUTC_INVALID = 3'd1;
	localparam logic [OUTC_W-1:0] OUTC_NEAR    = 3'd2;
	localparam logic [OUTC_W-1:0] OUTC_COLS    = 3'd3;
	localparam logic [OUTC_W-1:0] OUTC_ROWS    = 3'd4;

	// colour value sources
	localparam logic [1:0] VSRC_HEIGHT = 2'd1;
	localparam logic [1:0] VSRC_DIST   = 2'd2;

	// camera frame coordinates, mm Q.14
	localparam int CAM_W = 38;
	localparam logic signed [CAM_W-1:0] MIN_DEPTH_Q14 = CAM_W'(1000 * 16384);

	// divider: |c * f| / cz
	localparam int DIV_NUM_W = 53;
	localparam int DIV_DEN_W = 37;
	localparam int DIV_Q_W   = 30;

	// square root of x^2 + y^2 + z^2
	localparam int SQ_IN_W   = 40;
	localparam int SQ_OUT_W  = 20;
	localparam int SQ_SIDE_W = PT_W + INT_W;

	localparam int VAL_W   = 21;
	localparam int CPROD_W = 53;
	localparam int CSUM_W  = 54;

	// colour index waits for the divider
	localparam int COLOR_DLY = DIV_Q_W - SQ_OUT_W;

	localparam int COLOR_COUNT_DEF = 256;

	typedef struct packed {
		logic invalid;
		logic too_near;
	} lpcp_flags_t;

endpackage

[rtl/lpcp_stream_if.sv]
`timescale 1ns / 1ps
// Valid/ready stream interfaces for lidar points in and projected pixels out.
// Depends on lpcp_pkg for field widths.
interface lpcp_point_if;
	import lpcp_pkg::*;
	logic                     valid;
	logic                     ready;
	logic signed [PT_W-1:0]   point_x;
	logic signed [PT_W-1:0]   point_y;
	logic signed [PT_W-1:0]   point_z;
	logic [INT_W-1:0]         intensity;
	logic                     point_invalid;

	modport source (output valid, point_x, point_y, point_z, intensity, point_invalid,
		input ready);
	modport sink (input valid, point_x, point_y, point_z, intensity, point_invalid,
		output ready);
endinterface

interface lpcp_pixel_if;
	import lpcp_pkg::*;
	logic                     valid;
	logic                     ready;
	logic [OUTC_W-1:0]        outcome;
	logic signed [PIX_W-1:0]  pixel_x;
	logic signed [PIX_W-1:0]  pixel_y;
	logic [IDX_W-1:0]         color_index;

	modport source (output valid, outcome, pixel_x, pixel_y, color_index, input ready);
	modport sink (input valid, outcome, pixel_x, pixel_y, color_index, output ready);
endinterface

[rtl/lidar_point_camera_projection_core.sv]
`timescale 1ns / 1ps
// Lidar point to camera pixel projection. One point per cycle sustained while the
// pixel side does not stall, given the fully pipelined
// bit-per-stage dividers (31 stages) and square root (20 stages).
// A stall on the pixel side freezes the whole pipeline; nothing is dropped.
// Reset clears all valid bits and loads the default registers (raw 1 on the rotation diagonal).
// Depends on lpcp_pkg, lpcp_stream_if, lpcp_div and lpcp_sqrt.
module lidar_point_camera_projection_core #(
	parameter int COLOR_COUNT = lpcp_pkg::COLOR_COUNT_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [lpcp_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [lpcp_pkg::CFG_DATA_W-1:0]    cfg_data,
	lpcp_point_if.sink                         points,
	lpcp_pixel_if.source                       pixels
);
	import lpcp_pkg::*;

	localparam logic [IDX_W-1:0] CMAX = IDX_W'(COLOR_COUNT - 1);

	// registers
	logic [47:0] rot_q [3];
	logic [47:0] trans_q;
	logic [63:0] intr_q;
	logic [23:0] size_q;
	logic [63:0] color_q;
	logic [1:0]  vsrc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_q[0] <= 48'h0000_0000_0001;
			rot_q[1] <= 48'h0000_0001_0000;
			rot_q[2] <= 48'h0001_0000_0000;
			trans_q  <= '0;
			intr_q   <= '0;
			size_q   <= '0;
			color_q  <= '0;
			vsrc_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ROT0:  rot_q[0] <= cfg_data[47:0];
				CFG_ROT1:  rot_q[1] <= cfg_data[47:0];
				CFG_ROT2:  rot_q[2] <= cfg_data[47:0];
				CFG_TRANS: trans_q  <= cfg_data[47:0];
				CFG_INTR:  intr_q   <= cfg_data;
				CFG_SIZE:  size_q   <= cfg_data[23:0];
				CFG_COLOR: color_q  <= cfg_data;
				CFG_VSRC:  vsrc_q   <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	logic signed [15:0] rot_c [9];
	logic signed [29:0] trans_c [3];
	logic [15:0] fx, fy, ccx, ccy;
	logic [11:0] img_w, img_h;
	logic signed [31:0] c_scale, c_off;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				rot_c[3*i+j] = $signed(rot_q[i][16*j +: 16]);
			end
			trans_c[i] = $signed({trans_q[16*i +: 16], 14'd0});
		end
	end

	assign fx      = intr_q[15:0];
	assign fy      = intr_q[31:16];
	assign ccx     = intr_q[47:32];
	assign ccy     = intr_q[63:48];
	assign img_w   = size_q[11:0];
	assign img_h   = size_q[23:12];
	assign c_scale = $signed(color_q[31:0]);
	assign c_off   = $signed(color_q[63:32]);

	// whole pipeline advances together; the last stage is the output register
	logic en;
	logic vout_s35;

	assign en           = !vout_s35 || pixels.ready;
	assign points.ready = en;

	logic signed [PT_W-1:0] pt_c [3];
	assign pt_c[0] = points.point_x;
	assign pt_c[1] = points.point_y;
	assign pt_c[2] = points.point_z;

	// s1: coefficient products and squares
	logic                   v_s1, inv_s1;
	logic signed [35:0]     m_s1 [9];
	logic signed [39:0]     sq_s1 [3];
	logic signed [PT_W-1:0] pz_s1;
	logic [INT_W-1:0]       inten_s1;

	// s2: camera frame sums
	logic                   v_s2, inv_s2;
	logic signed [CAM_W-1:0] c_s2 [3];
	logic [SQ_IN_W-1:0]     sq_s2;
	logic signed [PT_W-1:0] pz_s2;
	logic [INT_W-1:0]       inten_s2;

	// s3: numerators, depth test
	logic                        v_s3, inv_s3, near_s3;
	logic signed [DIV_NUM_W-1:0] nx_s3, ny_s3;
	logic [DIV_DEN_W-1:0]        cz_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= points.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					m_s1[3*i+j] <= rot_c[3*i+j] * pt_c[j];
				end
				sq_s1[i] <= pt_c[i] * pt_c[i];
			end
			inv_s1   <= points.point_invalid;
			pz_s1    <= points.point_z;
			inten_s1 <= points.intensity;

			for (int i = 0; i < 3; i++) begin
				c_s2[i] <= m_s1[3*i] + m_s1[3*i+1] + m_s1[3*i+2] + trans_c[i];
			end
			sq_s2    <= $unsigned(sq_s1[0]) + $unsigned(sq_s1[1]) + $unsigned(sq_s1[2]);
			inv_s2   <= inv_s1;
			pz_s2    <= pz_s1;
			inten_s2 <= inten_s1;

			nx_s3   <= c_s2[0] * $signed({1'b0, fx});
			ny_s3   <= c_s2[1] * $signed({1'b0, fy});
			cz_s3   <= c_s2[2][DIV_DEN_W-1:0];
			near_s3 <= c_s2[2] < MIN_DEPTH_Q14;
			inv_s3  <= inv_s2;
		end
	end

	// s4..s34: dividers; the quotient is junk for culled points and is masked later
	lpcp_flags_t flg_in, du_flags, dv_flags;
	logic        du_valid, dv_valid, du_neg, dv_neg;
	logic [DIV_Q_W-1:0] du_q, dv_q;

	assign flg_in.invalid  = inv_s3;
	assign flg_in.too_near = near_s3;

	lpcp_div u_div_x (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s3),
		.num       (nx_s3),
		.den       (cz_s3),
		.in_flags  (flg_in),
		.out_valid (du_valid),
		.out_flags (du_flags),
		.out_neg   (du_neg),
		.quot      (du_q)
	);

	lpcp_div u_div_y (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s3),
		.num       (ny_s3),
		.den       (cz_s3),
		.in_flags  (flg_in),
		.out_valid (dv_valid),
		.out_flags (dv_flags),
		.out_neg   (dv_neg),
		.quot      (dv_q)
	);

	// colour path: s3..s22 square root, s23 product, s24 index, then delay to s34
	logic [SQ_OUT_W-1:0]  sq_root;
	logic [SQ_SIDE_W-1:0] sq_side;

	lpcp_sqrt u_sqrt (
		.clk      (clk),
		.en       (en),
		.rad      (sq_s2),
		.in_side  ({pz_s2, inten_s2}),
		.root     (sq_root),
		.out_side (sq_side)
	);

	logic signed [VAL_W-1:0]   cval;
	logic signed [CPROD_W-1:0] cprod_s23;
	logic signed [CSUM_W-1:0]  csum;
	logic [IDX_W-1:0]          cidx;
	logic [IDX_W-1:0]          cidx_s24;
	logic [IDX_W-1:0]          cdly_s [COLOR_DLY];

	always_comb begin
		case (vsrc_q)
			VSRC_HEIGHT: cval = VAL_W'($signed(sq_side[SQ_SIDE_W-1:INT_W]));
			VSRC_DIST:   cval = $signed({1'b0, sq_root});
			default:     cval = $signed(VAL_W'(sq_side[INT_W-1:0]));
		endcase
	end

	assign csum = cprod_s23 + c_off;

	always_comb begin
		if (csum[CSUM_W-1]) begin
			cidx = '0;
		end else if (csum[CSUM_W-1:16] > (CSUM_W-16)'(CMAX)) begin
			cidx = CMAX;
		end else begin
			cidx = csum[23:16];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cprod_s23 <= c_scale * cval;
			cidx_s24  <= cidx;
			cdly_s[0] <= cidx_s24;
			for (int k = 1; k < COLOR_DLY; k++) begin
				cdly_s[k] <= cdly_s[k-1];
			end
		end
	end

	// s35: pixel offsets, window tests, outcome
	logic signed [32:0] u_val, v_val, u_lo, u_hi, v_lo, v_hi;
	logic u_bad, v_bad;

	assign u_val = du_neg ? $signed({17'b0, ccx}) - $signed({3'b0, du_q})
	                      : $signed({17'b0, ccx}) + $signed({3'b0, du_q});
	assign v_val = dv_neg ? $signed({17'b0, ccy}) - $signed({3'b0, dv_q})
	                      : $signed({17'b0, ccy}) + $signed({3'b0, dv_q});
	assign u_lo  = -$signed({18'b0, img_w, 3'b0});
	assign u_hi  = $signed(33'(img_w) * 33'd24);
	assign v_lo  = -$signed({18'b0, img_h, 3'b0});
	assign v_hi  = $signed(33'(img_h) * 33'd24);
	assign u_bad = (u_val < u_lo) || (u_val > u_hi);
	assign v_bad = (v_val < v_lo) || (v_val > v_hi);

	logic [OUTC_W-1:0]       outc;
	logic [OUTC_W-1:0]       outc_s35;
	logic signed [PIX_W-1:0] px_s35, py_s35;
	logic [IDX_W-1:0]        cidx_s35;

	always_comb begin
		if (du_flags.invalid) begin
			outc = OUTC_INVALID;
		end else if (du_flags.too_near) begin
			outc = OUTC_NEAR;
		end else if (u_bad) begin
			outc = OUTC_COLS;
		end else if (v_bad) begin
			outc = OUTC_ROWS;
		end else begin
			outc = OUTC_KEPT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vout_s35 <= 1'b0;
		end else if (en) begin
			vout_s35 <= du_valid && dv_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			outc_s35 <= outc;
			px_s35   <= (outc == OUTC_KEPT) ? u_val[PIX_W-1:0] : '0;
			py_s35   <= (outc == OUTC_KEPT) ? v_val[PIX_W-1:0] : '0;
			cidx_s35 <= (outc == OUTC_KEPT) ? cdly_s[COLOR_DLY-1] : '0;
		end
	end

	// y-path flags match the x-path ones
	logic unused_flags;
	assign unused_flags = dv_flags.invalid ^ dv_flags.too_near;

	assign pixels.valid       = vout_s35 && !(unused_flags && 1'b0);
	assign pixels.outcome     = outc_s35;
	assign pixels.pixel_x     = px_s35;
	assign pixels.pixel_y     = py_s35;
	assign pixels.color_index = cidx_s35;

endmodule

[rtl/lpcp_div.sv]
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit per stage, truncating toward zero.
// Depends on lpcp_pkg for widths and the flag struct.
module lpcp_div (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  en,
	input  logic                                  in_valid,
	input  logic signed [lpcp_pkg::DIV_NUM_W-1:0] num,
	input  logic [lpcp_pkg::DIV_DEN_W-1:0]        den,
	input  lpcp_pkg::lpcp_flags_t                 in_flags,
	output logic                                  out_valid,
	output lpcp_pkg::lpcp_flags_t                 out_flags,
	output logic                                  out_neg,
	output logic [lpcp_pkg::DIV_Q_W-1:0]          quot
);
	import lpcp_pkg::*;

	localparam int QW    = DIV_Q_W;
	localparam int DW    = DIV_DEN_W;
	localparam int MAG_W = DIV_NUM_W - 1;

	logic        vld_s [QW+1];
	lpcp_flags_t flg_s [QW+1];
	logic        neg_s [QW+1];
	logic [DW-1:0] den_s [QW];
	logic [DW-1:0] rem_s [QW];
	logic [QW-1:0] low_s [QW];
	logic [QW-1:0] quo_s [1:QW];

	logic [MAG_W-1:0] mag;

	assign mag = num[DIV_NUM_W-1] ? MAG_W'($unsigned(-num)) : MAG_W'($unsigned(num));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_valid;
		end
	end

	// quotient is known to fit QW bits, so the top of the dividend seeds the remainder
	always_ff @(posedge clk) begin
		if (en) begin
			flg_s[0] <= in_flags;
			neg_s[0] <= num[DIV_NUM_W-1];
			den_s[0] <= den;
			rem_s[0] <= DW'(mag[MAG_W-1:QW]);
			low_s[0] <= mag[QW-1:0];
		end
	end

	for (genvar k = 1; k <= QW; k++) begin : g_step
		localparam int B = QW - k;
		logic [DW:0]   trial;
		logic          ge;
		logic [QW-1:0] qprev;
		logic [QW-1:0] qnext;

		assign trial = {rem_s[k-1], low_s[k-1][B]};
		assign ge    = trial >= {1'b0, den_s[k-1]};

		if (k == 1) begin : g_first
			assign qprev = '0;
		end else begin : g_rest
			assign qprev = quo_s[k-1];
		end

		always_comb begin
			qnext    = qprev;
			qnext[B] = ge;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				flg_s[k] <= flg_s[k-1];
				neg_s[k] <= neg_s[k-1];
				quo_s[k] <= qnext;
			end
		end

		if (k < QW) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					den_s[k] <= den_s[k-1];
					rem_s[k] <= ge ? DW'(trial - {1'b0, den_s[k-1]}) : DW'(trial);
					low_s[k] <= low_s[k-1];
				end
			end
		end
	end

	assign out_valid = vld_s[QW];
	assign out_flags = flg_s[QW];
	assign out_neg   = neg_s[QW];
	assign quot      = quo_s[QW];

endmodule

[rtl/lpcp_sqrt.sv]
`timescale 1ns / 1ps
// Pipelined integer square root, one root bit per stage, with a passed-along side word.
// Depends on lpcp_pkg for widths.
module lpcp_sqrt (
	input  logic                              clk,
	input  logic                              en,
	input  logic [lpcp_pkg::SQ_IN_W-1:0]      rad,
	input  logic [lpcp_pkg::SQ_SIDE_W-1:0]    in_side,
	output logic [lpcp_pkg::SQ_OUT_W-1:0]     root,
	output logic [lpcp_pkg::SQ_SIDE_W-1:0]    out_side
);
	import lpcp_pkg::*;

	localparam int OW = SQ_OUT_W;
	localparam int TW = 2 * OW;

	logic [TW-1:0]        rem_s  [1:OW-1];
	logic [OW-1:0]        root_s [1:OW];
	logic [SQ_SIDE_W-1:0] side_s [1:OW];

	for (genvar k = 1; k <= OW; k++) begin : g_step
		localparam int B = OW - k;
		logic [TW-1:0]        rprev;
		logic [OW-1:0]        qprev;
		logic [SQ_SIDE_W-1:0] sprev;
		logic [TW-1:0]        tst;
		logic                 ge;
		logic [OW-1:0]        qnext;

		if (k == 1) begin : g_first
			assign rprev = TW'(rad);
			assign qprev = '0;
			assign sprev = in_side;
		end else begin : g_rest
			assign rprev = rem_s[k-1];
			assign qprev = root_s[k-1];
			assign sprev = side_s[k-1];
		end

		// (r + 2^B)^2 - r^2 = r * 2^(B+1) + 2^(2B); root bits so far all sit above B
		assign tst = (TW'(qprev) << (B + 1)) | (TW'(1) << (2 * B));
		assign ge  = rprev >= tst;

		always_comb begin
			qnext    = qprev;
			qnext[B] = ge;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				root_s[k] <= qnext;
				side_s[k] <= sprev;
			end
		end

		if (k < OW) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k] <= ge ? rprev - tst : rprev;
				end
			end
		end
	end

	assign root     = root_s[OW];
	assign out_side = side_s[OW];

endmodule
